>>> src/sorted_priority_queue_unit_assert.svh
// assertion macros for the sorted priority queue unit
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/spq_pkg.sv
// shared types and constants of the sorted priority queue
`default_nettype none
package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int COUNT_OUT_W = 5;

  localparam logic [1:0] ACT_QUERY = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_POP   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic                   head_valid;
    logic [DATA_W-1:0]      head_value;
    logic [DATA_W-1:0]      head_priority;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [1:0]             status;
  } result_t;

endpackage
`default_nettype wire

>>> src/spq_ram.sv
// entry store: one write port, one registered read port
`default_nettype none
module spq_ram (
  input  wire logic              clk,
  input  wire spq_pkg::ram_req_t req,
  output spq_pkg::entry_t        rd_data
);
  import spq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule
`default_nettype wire

>>> src/spq_ctrl.sv
// sequencer: insertion shift, pop shift and head fetch over the entry store
`default_nettype none
module spq_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_accept,
  input  wire logic [1:0]                  action,
  input  wire logic signed [spq_pkg::DATA_W-1:0] item_value,
  input  wire logic signed [spq_pkg::DATA_W-1:0] item_priority,
  input  wire spq_pkg::entry_t             rd_data,
  input  wire logic                        out_free,
  output spq_pkg::ram_req_t                ram_req,
  output logic                             idle,
  output logic                             res_load,
  output spq_pkg::result_t                 res
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_PRD   = 3'd4;
  localparam logic [2:0] S_PWR   = 3'd5;
  localparam logic [2:0] S_HEAD  = 3'd6;
  localparam logic [2:0] S_LOAD  = 3'd7;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] k, k_next;
  logic [1:0]       status, status_next;
  entry_t           new_entry;

  logic [CNT_W-1:0] k_dec, k_inc, k_inc2;
  logic             higher;

  assign k_dec  = k - CNT_W'(1);
  assign k_inc  = k + CNT_W'(1);
  assign k_inc2 = k + CNT_W'(2);
  // shared comparator: stored entry outranks the new one
  assign higher = $signed(rd_data.prio) > $signed(new_entry.prio);

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    count_next  = count;
    k_next      = k;
    status_next = status;
    ram_req     = '0;
    res_load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          status_next = ST_DONE;
          state_next  = S_HEAD;
          unique case (action)
            ACT_PUSH: begin
              if (count == CNT_W'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                k_next     = count;
                state_next = (count == '0) ? S_PLACE : S_RD;
              end
            end
            ACT_POP: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else if (count == CNT_W'(1)) begin
                count_next = '0;
              end else begin
                k_next     = '0;
                state_next = S_PRD;
              end
            end
            default: begin
              state_next = S_HEAD;
            end
          endcase
        end
      end
      S_RD: begin
        ram_req.raddr = k_dec[IDX_W-1:0];
        state_next    = S_CMP;
      end
      S_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = k[IDX_W-1:0];
        if (higher) begin
          ram_req.wdata = new_entry;
          count_next    = count + CNT_W'(1);
          state_next    = S_HEAD;
        end else begin
          ram_req.wdata = rd_data;
          k_next        = k_dec;
          state_next    = (k == CNT_W'(1)) ? S_PLACE : S_RD;
        end
      end
      S_PLACE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = new_entry;
        count_next    = count + CNT_W'(1);
        state_next    = S_HEAD;
      end
      S_PRD: begin
        ram_req.raddr = k_inc[IDX_W-1:0];
        state_next    = S_PWR;
      end
      S_PWR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = k[IDX_W-1:0];
        ram_req.wdata = rd_data;
        k_next        = k_inc;
        if (k_inc2 == count) begin
          count_next = count - CNT_W'(1);
          state_next = S_HEAD;
        end else begin
          state_next = S_PRD;
        end
      end
      S_HEAD: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        // raddr stays at zero so the head word holds while waiting
        res_load = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.head_valid    = (count != '0);
    res.head_value    = (count != '0) ? rd_data.value : '0;
    res.head_priority = (count != '0) ? rd_data.prio : '0;
    res.entry_count   = COUNT_OUT_W'(count);
    res.status        = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      k      <= '0;
      status <= ST_DONE;
    end else begin
      state  <= state_next;
      count  <= count_next;
      k      <= k_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      new_entry.value <= item_value;
      new_entry.prio  <= item_priority;
    end
  end

endmodule
`default_nettype wire

>>> src/sorted_priority_queue_unit.sv
// top level of the sorted priority queue unit
// usage:
//   input channel (in_valid / in_stall) carries one request beat: action
//   (query, push, pop), item_value and item_priority. a push inserts the pair
//   ahead of every stored entry of lower or equal priority, so equal
//   priorities leave last-in-first-out. a pop drops the head.
//   output channel (out_valid / out_stall) carries one result beat per
//   request: head flag, head value and priority, entry count and status
//   (done, push dropped because full, pop on empty ignored).
// sequencing:
//   one request at a time; in_stall is high while the sequencer works.
//   each entry moved takes one store read and one store write. a query,
//   a rejected request or a pop of the last entry goes straight to the
//   head fetch; a pop shifts each remaining entry one place toward the
//   head; a push shifts entries one place toward the tail until a compare
//   stops it or it lands at the head. the next request can be taken in the
//   cycle after the result loads, even while it still waits on out_stall.
// reset: rst (synchronous) empties the queue and clears out_valid; the entry
//   store itself is not cleared, only live positions are ever used.
// stall: a held result stays stable; the sequencer waits in its last step
//   until the result register is free.
`default_nettype none
`include "sorted_priority_queue_unit_assert.svh"
module sorted_priority_queue_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           action,
  input  wire logic signed [spq_pkg::DATA_W-1:0]    item_value,
  input  wire logic signed [spq_pkg::DATA_W-1:0]    item_priority,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      head_valid,
  output logic signed [spq_pkg::DATA_W-1:0]         head_value,
  output logic signed [spq_pkg::DATA_W-1:0]         head_priority,
  output logic [spq_pkg::COUNT_OUT_W-1:0]           entry_count,
  output logic [1:0]                                status
);
  import spq_pkg::*;

  logic     in_accept;
  logic     idle;
  logic     res_load;
  logic     out_free;
  ram_req_t ram_req;
  entry_t   rd_data;
  result_t  res;

  // requests are taken only while the sequencer sits idle
  assign in_stall  = !idle;
  assign in_accept = in_valid && !in_stall;
  // result register can take a new beat when empty or draining this cycle
  assign out_free  = !out_valid || !out_stall;

  spq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  spq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_accept     (in_accept),
    .action        (action),
    .item_value    (item_value),
    .item_priority (item_priority),
    .rd_data       (rd_data),
    .out_free      (out_free),
    .ram_req       (ram_req),
    .idle          (idle),
    .res_load      (res_load),
    .res           (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      head_valid    <= res.head_valid;
      head_value    <= res.head_value;
      head_priority <= res.head_priority;
      entry_count   <= res.entry_count;
      status        <= res.status;
    end
  end

  // a new result never overwrites one that is still held
  `SPQ_ASSERT_NOW(a_load_when_free, res_load, out_free, "result overwritten while stalled")
  // an accepted request makes the block busy on the next cycle
  `SPQ_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall, "accepted request left block idle")
  // head flag agrees with the count, count never exceeds the depth
  `SPQ_ASSERT_NOW(a_head_matches_count, res_load,
    (res.head_valid == (res.entry_count != '0)) &&
    (res.entry_count <= COUNT_OUT_W'(DEPTH)), "head flag or count inconsistent")
  // a dropped push only happens on a full queue
  `SPQ_ASSERT_NOW(a_full_drop, res_load && (res.status == ST_FULL),
    res.entry_count == COUNT_OUT_W'(DEPTH), "push dropped while not full")

endmodule
`default_nettype wire

>>> sim/sorted_priority_queue_unit_test.sv
// self-checking testbench of the sorted priority queue unit
`timescale 1ns / 100ps

module sorted_priority_queue_unit_test;
  import spq_pkg::*;

  // action code 3 is unused by the block and behaves as a query
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 600;
  localparam int MAX_REPORTS  = 10;
  localparam int QUIET_FROM   = 4000;
  localparam int QUIET_TO     = 7000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    bit                       hold_off;  // wait until all results are back
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               action = ACT_QUERY;
  logic signed [DATA_W-1:0] item_value = '0;
  logic signed [DATA_W-1:0] item_priority = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     head_valid;
  logic signed [DATA_W-1:0] head_value;
  logic signed [DATA_W-1:0] head_priority;
  logic [COUNT_OUT_W-1:0]   entry_count;
  logic [1:0]               status;

  sorted_priority_queue_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .item_value    (item_value),
    .item_priority (item_priority),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .head_valid    (head_valid),
    .head_value    (head_value),
    .head_priority (head_priority),
    .entry_count   (entry_count),
    .status        (status)
  );

  // shadow copy of the sorted store, head at index zero
  logic signed [DATA_W-1:0] shadow_value [DEPTH];
  logic signed [DATA_W-1:0] shadow_prio  [DEPTH];
  int unsigned              shadow_count = 0;

  request_t pending_reqs[$];
  result_t  expected_heads[$];

  int unsigned cyc = 0;
  int unsigned n_fail = 0;
  int unsigned n_push = 0, n_pop = 0, n_query = 0, n_full = 0, n_empty = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // random idling on both sides, except inside one quiet window
  function automatic bit idle_now();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 22;
  endfunction

  // advance the shadow queue by one request and form the expected result beat
  task automatic apply_request(input request_t req, output result_t res);
    int unsigned pos;
    int unsigned k;
    logic [1:0]  st;
    st = ST_DONE;
    case (req.action)
      ACT_PUSH: begin
        n_push++;
        if (shadow_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] > req.prio) pos++;
          for (k = shadow_count; k > pos; k--) begin
            shadow_value[k] = shadow_value[k-1];
            shadow_prio[k]  = shadow_prio[k-1];
          end
          shadow_value[pos] = req.value;
          shadow_prio[pos]  = req.prio;
          shadow_count++;
        end
      end
      ACT_POP: begin
        n_pop++;
        if (shadow_count == 0) begin
          st = ST_EMPTY;
        end else begin
          for (k = 0; k + 1 < shadow_count; k++) begin
            shadow_value[k] = shadow_value[k+1];
            shadow_prio[k]  = shadow_prio[k+1];
          end
          shadow_count--;
        end
      end
      default: n_query++;
    endcase
    if (st == ST_FULL) n_full++;
    if (st == ST_EMPTY) n_empty++;
    res.head_valid    = shadow_count != 0;
    res.head_value    = (shadow_count != 0) ? shadow_value[0] : '0;
    res.head_priority = (shadow_count != 0) ? shadow_prio[0] : '0;
    res.entry_count   = shadow_count[COUNT_OUT_W-1:0];
    res.status        = st;
  endtask

  task automatic add_req(input logic [1:0] act, input logic [DATA_W-1:0] val,
                         input logic [DATA_W-1:0] pri, input bit hold);
    request_t r;
    r.action   = act;
    r.value    = val;
    r.prio     = pri;
    r.hold_off = hold;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [DATA_W-1:0] pick_priority();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 7) - 3;  // narrow range gives many ties
    if (r < 75) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // stimulus: directed corners first, then bursts biased to fill, to drain or balanced
  initial begin : build_stimulus
    int unsigned n_rand;
    int unsigned burst;
    int unsigned mode;
    int unsigned r;
    logic [1:0]  act;

    add_req(ACT_QUERY, 32'h1234_5678, 32'h0, 1'b0);       // query on empty
    add_req(ACT_POP, 32'h0, 32'h0, 1'b0);                 // pop on empty
    add_req(ACT_SPARE, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_req(ACT_PUSH, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    add_req(ACT_PUSH, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_req(ACT_PUSH, 32'hffff_ffff, 32'h0, 1'b0);
    add_req(ACT_PUSH, 32'h0000_0005, 32'h0, 1'b0);        // tie: goes ahead
    add_req(ACT_POP, 32'h0, 32'h0, 1'b0);
    add_req(ACT_POP, 32'h0, 32'h0, 1'b0);
    add_req(ACT_POP, 32'h0, 32'h0, 1'b0);
    // fill to the top, then push into a full queue
    for (int i = 0; i < DEPTH - 1; i++)
      add_req(ACT_PUSH, $urandom, pick_priority(), 1'b0);
    add_req(ACT_PUSH, 32'hdead_beef, 32'h7fff_ffff, 1'b0); // full: dropped
    add_req(ACT_SPARE, 32'h0, 32'h0, 1'b1);

    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      mode  = $urandom_range(0, 2);
      burst = $urandom_range(8, 40);
      for (int i = 0; i < burst; i++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0:       act = (r < 65) ? ACT_PUSH : (r < 85) ? ACT_POP : (r < 95) ? ACT_QUERY
                                                                             : ACT_SPARE;
          1:       act = (r < 65) ? ACT_POP : (r < 85) ? ACT_PUSH : (r < 95) ? ACT_QUERY
                                                                             : ACT_SPARE;
          default: act = (r < 45) ? ACT_PUSH : (r < 90) ? ACT_POP : (r < 95) ? ACT_QUERY
                                                                             : ACT_SPARE;
        endcase
        add_req(act, $urandom, pick_priority(),
                (i == 0 && $urandom_range(0, 7) == 0) || $urandom_range(0, 99) == 0);
        n_rand++;
      end
    end
  end

  // driver: presents the front of the pending list, holds it while stalled
  always @(posedge clk) begin : drive_requests
    bit       fire;
    bit       present;
    request_t req;
    result_t  res;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        req = pending_reqs.pop_front();
        apply_request(req, res);
        expected_heads.push_back(res);
      end
      if (!in_valid || fire) begin
        present = pending_reqs.size() != 0 && !idle_now();
        if (present && pending_reqs[0].hold_off && expected_heads.size() != 0)
          present = 1'b0;
        if (present) begin
          req           = pending_reqs[0];
          action        <= req.action;
          item_value    <= req.value;
          item_priority <= req.prio;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_failure(input string msg);
    if (n_fail < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cyc, msg);
    n_fail++;
  endtask

  // monitor: checks each result beat against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_heads.size() == 0) begin
          note_failure("result beat with no request outstanding");
        end else begin
          want = expected_heads.pop_front();
          if (head_valid !== want.head_valid || head_value !== want.head_value ||
              head_priority !== want.head_priority ||
              entry_count !== want.entry_count || status !== want.status)
            note_failure($sformatf(
              "exp valid=%0d value=%0d prio=%0d count=%0d status=%0d, got %0d %0d %0d %0d %0d",
              want.head_valid, $signed(want.head_value), $signed(want.head_priority),
              want.entry_count, want.status, head_valid, head_value, head_priority,
              entry_count, status));
        end
      end
      out_stall <= idle_now();
    end
  end

  initial begin : finish_run
    @(negedge rst);
    while (pending_reqs.size() != 0 || in_valid || expected_heads.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_heads.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_heads.size()));
    $display("ran %0d pushes, %0d pops, %0d queries or spare codes",
             n_push, n_pop, n_query);
    $display("saw %0d pushes into a full queue and %0d pops on an empty one; %0d failures",
             n_full, n_empty, n_fail);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/spq_pkg.sv
src/spq_ram.sv
src/spq_ctrl.sv
src/sorted_priority_queue_unit.sv
sim/sorted_priority_queue_unit_test.sv
